FILE: src/sbag_pkg.sv
// ----------------------------------------------------------------------------
// Scratch buffer alias grouper package
// Shared types, constants and helper functions for the grouper block.
// ----------------------------------------------------------------------------
`default_nettype none

package sbag_pkg;

    // Table and field sizes.
    localparam int MAX_GROUPS = 16;
    localparam int STAGE_BITS = 12;
    localparam int GIDX_W     = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int COUNT_W    = $clog2(MAX_GROUPS + 1);
    localparam int KIND_W     = 4;
    localparam int COUNT_IN_W = 40;
    localparam int SIZE_W     = 42;
    localparam int TOTAL_W    = 48;

    // Tensor kind codes.
    localparam logic [KIND_W-1:0] KIND_FP32   = 4'd0;
    localparam logic [KIND_W-1:0] KIND_INT32  = 4'd1;
    localparam logic [KIND_W-1:0] KIND_BF16   = 4'd2;
    localparam logic [KIND_W-1:0] KIND_FP16   = 4'd3;
    localparam logic [KIND_W-1:0] KIND_Q8_0   = 4'd4;
    localparam logic [KIND_W-1:0] KIND_Q8_1   = 4'd5;
    localparam logic [KIND_W-1:0] KIND_Q4_0   = 4'd6;
    localparam logic [KIND_W-1:0] KIND_IQ4_NL = 4'd7;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SIZE,
        ST_ORIG,
        ST_SCAN,
        ST_HIT,
        ST_OPEN,
        ST_ADDOPT,
        ST_OUT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // latch the input item and clear result flags
        logic calc_size;  // compute the byte size
        logic orig;       // original total, clear item, order check
        logic scan_next;  // advance the scan index
        logic hit;        // join the group at the scan index
        logic open;       // open a new group or flag a full table
        logic addopt;     // add the pending amount to the optimized total
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic mode;
        logic scratch;
        logic scan_end;
        logic scan_hit;
    } status_t;

    // Byte size of a buffer by kind and element count.
    function automatic logic [SIZE_W-1:0] buffer_size(
        input logic [KIND_W-1:0]     kind,
        input logic [COUNT_IN_W-1:0] n
    );
        logic [SIZE_W-1:0] nx;
        logic [SIZE_W-1:0] half;
        logic [SIZE_W-1:0] blocks;
        logic [SIZE_W-1:0] result;
        nx     = SIZE_W'(n);
        half   = (nx + SIZE_W'(1)) >> 1;
        blocks = (nx >> 5) << 2;
        case (kind)
            KIND_BF16, KIND_FP16:   result = nx << 1;
            KIND_Q8_0, KIND_Q8_1:   result = nx;
            KIND_Q4_0, KIND_IQ4_NL: result = half + blocks;
            default:                result = nx << 2;
        endcase
        return result;
    endfunction

    // True for the float kinds that may share storage.
    function automatic logic is_float_kind(input logic [KIND_W-1:0] k);
        return (k == KIND_FP32) || (k == KIND_BF16) || (k == KIND_FP16);
    endfunction

    function automatic logic kinds_match(
        input logic [KIND_W-1:0] a,
        input logic [KIND_W-1:0] b
    );
        return (a == b) || (is_float_kind(a) && is_float_kind(b));
    endfunction

    // Saturating add of a size onto a running total.
    function automatic logic [TOTAL_W-1:0] sat_add(
        input logic [TOTAL_W-1:0] a,
        input logic [SIZE_W-1:0]  b
    );
        logic [TOTAL_W:0] s;
        s = {1'b0, a} + (TOTAL_W + 1)'(b);
        return s[TOTAL_W] ? {TOTAL_W{1'b1}} : s[TOTAL_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: src/sbag_ctrl.sv
// ----------------------------------------------------------------------------
// Scratch buffer alias grouper controller
// Sequences size, totals, group scan and update for one item at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module sbag_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  wire logic             out_ready,
    input  wire sbag_pkg::status_t status,
    output sbag_pkg::cmd_t        cmd
);

    sbag_pkg::state_t state_reg;
    sbag_pkg::state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sbag_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sbag_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = sbag_pkg::ST_SIZE;
                end
            end
            sbag_pkg::ST_SIZE:
            begin
                state_next = sbag_pkg::ST_ORIG;
            end
            sbag_pkg::ST_ORIG:
            begin
                if (status.mode)
                begin
                    state_next = sbag_pkg::ST_OUT;
                end
                else if (status.scratch)
                begin
                    state_next = sbag_pkg::ST_SCAN;
                end
                else
                begin
                    state_next = sbag_pkg::ST_ADDOPT;
                end
            end
            sbag_pkg::ST_SCAN:
            begin
                if (status.scan_end)
                begin
                    state_next = sbag_pkg::ST_OPEN;
                end
                else if (status.scan_hit)
                begin
                    state_next = sbag_pkg::ST_HIT;
                end
            end
            sbag_pkg::ST_HIT, sbag_pkg::ST_OPEN:
            begin
                state_next = sbag_pkg::ST_ADDOPT;
            end
            sbag_pkg::ST_ADDOPT:
            begin
                state_next = sbag_pkg::ST_OUT;
            end
            sbag_pkg::ST_OUT:
            begin
                if (out_ready)
                begin
                    state_next = sbag_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sbag_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs and datapath commands.
    always_comb
    begin
        cmd       = '0;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            sbag_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            sbag_pkg::ST_SIZE:   cmd.calc_size = 1'b1;
            sbag_pkg::ST_ORIG:   cmd.orig = 1'b1;
            sbag_pkg::ST_SCAN:   cmd.scan_next = !status.scan_end && !status.scan_hit;
            sbag_pkg::ST_HIT:    cmd.hit = 1'b1;
            sbag_pkg::ST_OPEN:   cmd.open = 1'b1;
            sbag_pkg::ST_ADDOPT: cmd.addopt = 1'b1;
            sbag_pkg::ST_OUT:    out_valid = 1'b1;
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: src/sbag_dp.sv
// ----------------------------------------------------------------------------
// Scratch buffer alias grouper datapath
// Group table, running totals, size unit and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module sbag_dp (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire sbag_pkg::cmd_t                      cmd,
    output sbag_pkg::status_t                        status,
    input  wire logic                                mode,
    input  wire logic [sbag_pkg::STAGE_BITS-1:0]     first_use,
    input  wire logic [sbag_pkg::STAGE_BITS-1:0]     last_use,
    input  wire logic [sbag_pkg::KIND_W-1:0]         tensor_kind,
    input  wire logic [sbag_pkg::COUNT_IN_W-1:0]     element_count,
    input  wire logic                                is_scratch,
    output logic [sbag_pkg::SIZE_W-1:0]              byte_size,
    output logic                                     aliased,
    output logic [sbag_pkg::GIDX_W-1:0]              group_index,
    output logic                                     opened_group,
    output logic [sbag_pkg::SIZE_W-1:0]              group_bytes,
    output logic [sbag_pkg::COUNT_W-1:0]             groups_in_use,
    output logic [sbag_pkg::TOTAL_W-1:0]             original_total,
    output logic [sbag_pkg::TOTAL_W-1:0]             optimized_total,
    output logic                                     table_full,
    output logic                                     out_of_order
);

    // Latched input item.
    logic                               mode_reg;
    logic [sbag_pkg::STAGE_BITS-1:0]    first_reg;
    logic [sbag_pkg::STAGE_BITS-1:0]    last_reg;
    logic [sbag_pkg::KIND_W-1:0]        kind_reg;
    logic [sbag_pkg::COUNT_IN_W-1:0]    n_reg;
    logic                               scratch_reg;

    // Group table; entries at or above the group count are never read.
    logic [sbag_pkg::STAGE_BITS-1:0]    grp_end_reg  [sbag_pkg::MAX_GROUPS];
    logic [sbag_pkg::KIND_W-1:0]        grp_kind_reg [sbag_pkg::MAX_GROUPS];
    logic [sbag_pkg::SIZE_W-1:0]        grp_max_reg  [sbag_pkg::MAX_GROUPS];

    // Persistent state and result registers.
    logic [sbag_pkg::COUNT_W-1:0]       count_reg;
    logic [sbag_pkg::STAGE_BITS-1:0]    prev_first_reg;
    logic [sbag_pkg::TOTAL_W-1:0]       sum_orig_reg;
    logic [sbag_pkg::TOTAL_W-1:0]       sum_opt_reg;
    logic [sbag_pkg::COUNT_W-1:0]       idx_reg;
    logic [sbag_pkg::SIZE_W-1:0]        size_reg;
    logic [sbag_pkg::SIZE_W-1:0]        addend_reg;
    logic                               aliased_reg;
    logic [sbag_pkg::GIDX_W-1:0]        gidx_reg;
    logic                               opened_reg;
    logic [sbag_pkg::SIZE_W-1:0]        gbytes_reg;
    logic                               full_reg;
    logic                               ooo_reg;

    // Entry under the scan index.
    logic [sbag_pkg::GIDX_W-1:0]        sel;
    logic [sbag_pkg::GIDX_W-1:0]        new_idx;
    logic [sbag_pkg::STAGE_BITS-1:0]    sel_end;
    logic [sbag_pkg::KIND_W-1:0]        sel_kind;
    logic [sbag_pkg::SIZE_W-1:0]        sel_max;
    logic                               table_has_room;

    assign sel      = idx_reg[sbag_pkg::GIDX_W-1:0];
    assign new_idx  = count_reg[sbag_pkg::GIDX_W-1:0];
    assign sel_end  = grp_end_reg[sel];
    assign sel_kind = grp_kind_reg[sel];
    assign sel_max  = grp_max_reg[sel];
    assign table_has_room = count_reg < sbag_pkg::COUNT_W'(sbag_pkg::MAX_GROUPS);

    // Status back to the controller.
    always_comb
    begin
        status.mode     = mode_reg;
        status.scratch  = scratch_reg;
        status.scan_end = (idx_reg == count_reg);
        status.scan_hit = (first_reg > sel_end) && sbag_pkg::kinds_match(kind_reg, sel_kind);
    end

    // Input latch and size register.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg    <= mode;
            first_reg   <= first_use;
            last_reg    <= last_use;
            kind_reg    <= tensor_kind;
            n_reg       <= element_count;
            scratch_reg <= is_scratch;
        end
        if (cmd.calc_size)
        begin
            size_reg <= mode_reg ? '0 : sbag_pkg::buffer_size(kind_reg, n_reg);
        end
    end

    // Group table writes: join at the scan index or open at the group count.
    always_ff @(posedge clk)
    begin
        if (cmd.hit)
        begin
            if (size_reg > sel_max)
            begin
                grp_max_reg[sel] <= size_reg;
            end
            if (last_reg > sel_end)
            begin
                grp_end_reg[sel] <= last_reg;
            end
        end
        else if (cmd.open && table_has_room)
        begin
            grp_end_reg[new_idx]  <= last_reg;
            grp_kind_reg[new_idx] <= kind_reg;
            grp_max_reg[new_idx]  <= size_reg;
        end
    end

    // Pending amount for the optimized total.
    always_ff @(posedge clk)
    begin
        if (cmd.orig)
        begin
            addend_reg <= size_reg;
        end
        else if (cmd.hit)
        begin
            addend_reg <= (size_reg > sel_max) ? (size_reg - sel_max) : '0;
        end
        else if (cmd.open)
        begin
            addend_reg <= size_reg;
        end
    end

    // Control state, totals and result flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            prev_first_reg <= '0;
            sum_orig_reg   <= '0;
            sum_opt_reg    <= '0;
            idx_reg        <= '0;
            aliased_reg    <= 1'b0;
            gidx_reg       <= '0;
            opened_reg     <= 1'b0;
            gbytes_reg     <= '0;
            full_reg       <= 1'b0;
            ooo_reg        <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                aliased_reg <= 1'b0;
                gidx_reg    <= '0;
                opened_reg  <= 1'b0;
                gbytes_reg  <= '0;
                full_reg    <= 1'b0;
                ooo_reg     <= 1'b0;
                idx_reg     <= '0;
            end
            if (cmd.orig)
            begin
                if (mode_reg)
                begin
                    // A clear item empties the table and zeroes the totals.
                    count_reg      <= '0;
                    prev_first_reg <= '0;
                    sum_orig_reg   <= '0;
                    sum_opt_reg    <= '0;
                end
                else
                begin
                    sum_orig_reg <= sbag_pkg::sat_add(sum_orig_reg, size_reg);
                    if (scratch_reg)
                    begin
                        ooo_reg        <= first_reg < prev_first_reg;
                        prev_first_reg <= first_reg;
                    end
                end
            end
            if (cmd.scan_next)
            begin
                idx_reg <= idx_reg + sbag_pkg::COUNT_W'(1);
            end
            if (cmd.hit)
            begin
                aliased_reg <= 1'b1;
                gidx_reg    <= sel;
                gbytes_reg  <= (size_reg > sel_max) ? size_reg : sel_max;
            end
            if (cmd.open)
            begin
                if (table_has_room)
                begin
                    count_reg   <= count_reg + sbag_pkg::COUNT_W'(1);
                    aliased_reg <= 1'b1;
                    opened_reg  <= 1'b1;
                    gidx_reg    <= new_idx;
                    gbytes_reg  <= size_reg;
                end
                else
                begin
                    full_reg <= 1'b1;
                end
            end
            if (cmd.addopt)
            begin
                sum_opt_reg <= sbag_pkg::sat_add(sum_opt_reg, addend_reg);
            end
        end
    end

    // Result fields straight from the registers.
    assign byte_size       = size_reg;
    assign aliased         = aliased_reg;
    assign group_index     = gidx_reg;
    assign opened_group    = opened_reg;
    assign group_bytes     = gbytes_reg;
    assign groups_in_use   = count_reg;
    assign original_total  = sum_orig_reg;
    assign optimized_total = sum_opt_reg;
    assign table_full      = full_reg;
    assign out_of_order    = ooo_reg;

endmodule

`default_nettype wire

FILE: src/scratch_buffer_alias_grouper.sv
// ----------------------------------------------------------------------------
// Scratch buffer alias grouper
// Greedy first-fit grouping of scratch buffers by lifetime and tensor kind.
// ----------------------------------------------------------------------------
// The block takes one item at a time: in_ready is high only while it is idle,
// and the result is held on the output ports until out_ready takes it. After
// an item is accepted, the block computes its byte size and adds it to the
// original total; a scratch item then scans the group table, reading one
// entry per cycle, up to the group it joins, or through all groups in use
// when it opens a group or finds the table full, and then joins or opens a
// group. Every item but a mode item then adds to the optimized total, and
// the result is presented; a buffer that is not scratch skips the scan.
// Items should arrive in nondecreasing first-use order; a scratch item that
// breaks this order is flagged in out_of_order and still placed. A mode item
// clears the table and both totals and returns an all-zero result.
`default_nettype none

module scratch_buffer_alias_grouper (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic                              mode,
    input  wire logic [sbag_pkg::STAGE_BITS-1:0]   first_use,
    input  wire logic [sbag_pkg::STAGE_BITS-1:0]   last_use,
    input  wire logic [sbag_pkg::KIND_W-1:0]       tensor_kind,
    input  wire logic [sbag_pkg::COUNT_IN_W-1:0]   element_count,
    input  wire logic                              is_scratch,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [sbag_pkg::SIZE_W-1:0]            byte_size,
    output logic                                   aliased,
    output logic [sbag_pkg::GIDX_W-1:0]            group_index,
    output logic                                   opened_group,
    output logic [sbag_pkg::SIZE_W-1:0]            group_bytes,
    output logic [sbag_pkg::COUNT_W-1:0]           groups_in_use,
    output logic [sbag_pkg::TOTAL_W-1:0]           original_total,
    output logic [sbag_pkg::TOTAL_W-1:0]           optimized_total,
    output logic                                   table_full,
    output logic                                   out_of_order
);

    sbag_pkg::cmd_t    cmd;
    sbag_pkg::status_t status;

    // Sequencer.
    sbag_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Group table, totals and result registers.
    sbag_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .mode            (mode),
        .first_use       (first_use),
        .last_use        (last_use),
        .tensor_kind     (tensor_kind),
        .element_count   (element_count),
        .is_scratch      (is_scratch),
        .byte_size       (byte_size),
        .aliased         (aliased),
        .group_index     (group_index),
        .opened_group    (opened_group),
        .group_bytes     (group_bytes),
        .groups_in_use   (groups_in_use),
        .original_total  (original_total),
        .optimized_total (optimized_total),
        .table_full      (table_full),
        .out_of_order    (out_of_order)
    );

endmodule

`default_nettype wire
